// ===== sv/omni_wheel_goal_velocity_top_macros.svh =====
// Assertion macros for the omni wheel goal velocity block.
`ifndef OMNI_WHEEL_GOAL_VELOCITY_TOP_MACROS_SVH
`define OMNI_WHEEL_GOAL_VELOCITY_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OWGV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OWGV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/owgv_pkg.sv =====
// Package with constants, types and tables of the omni wheel goal velocity block.
package owgv_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int MUL_W   = 48;
  localparam int MUL_DIG = 4;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [47:0] TURN_PER_RAD = 48'sd683565276;
  localparam logic signed [47:0] HALF_SQRT2   = 48'sd759250125;
  localparam logic [40:0]        PROD_LIM     = 41'd1099511627776;

  typedef enum logic [2:0] {
    REG_NEAR_GAIN  = 3'd0,
    REG_FAR_GAIN   = 3'd1,
    REG_INNER_RAD  = 3'd2,
    REG_OUTER_RAD  = 3'd3,
    REG_INV_WHEEL  = 3'd4,
    REG_AXLE       = 3'd5
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_SQX, S_SQY, S_SQI, S_SQO, S_GAIN, S_ANG, S_CORD, S_CLMP,
    S_XC, S_YS, S_XS, S_YC, S_UV, S_PA, S_PB, S_HD, S_KA, S_KB, S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn).
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051E;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -43'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/owgv_if.sv =====
// Valid/ready channel interfaces for pose/goal words and wheel speed words.
interface owgv_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] heading;
  modport source (output valid, cmd, coord_x, coord_y, heading, input ready);
  modport sink (input valid, cmd, coord_x, coord_y, heading, output ready);
endinterface

interface owgv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel_a_speed;
  logic signed [31:0] wheel_b_speed;
  logic signed [31:0] wheel_c_speed;
  logic signed [31:0] wheel_d_speed;
  modport source (output valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
                  wheel_d_speed, input ready);
  modport sink (input valid, wheel_a_speed, wheel_b_speed, wheel_c_speed,
                wheel_d_speed, output ready);
endinterface

// ===== sv/owgv_smul.sv =====
// Digit-serial unsigned multiplier, one digit of the second operand per cycle.
module owgv_smul #(
  parameter int W   = owgv_pkg::MUL_W,
  parameter int DIG = owgv_pkg::MUL_DIG
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          a_in,
  input  logic [W-1:0]          b_in,
  output owgv_pkg::mul_stat_t   stat,
  output logic [2*W-1:0]        prod
);

  localparam int STEPS = W / DIG;
  localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic [W-1:0]     a;
  logic [W-1:0]     b;
  logic [2*W-1:0]   acc;
  logic [CW-1:0]    cnt;
  logic [W+DIG-1:0] pp;
  logic [W+DIG-1:0] hi_sum;
  logic [2*W+DIG-1:0] wide;

  // Add the digit's partial product to the upper half, then shift one digit down.
  always_comb begin
    pp     = {{DIG{1'b0}}, a} * {{W{1'b0}}, b[DIG-1:0]};
    hi_sum = {{DIG{1'b0}}, acc[2*W-1:W]} + pp;
    wide   = {hi_sum, acc[W-1:0]} >> DIG;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        a         <= a_in;
        b         <= b_in;
        acc       <= '0;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        acc <= wide[2*W-1:0];
        b   <= b >> DIG;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ===== sv/omni_wheel_goal_velocity_top.sv =====
// Top level of the four-wheel omni inverse kinematics goal velocity block.
//
//  channel | dir | handshake           | word
//  in_ch   | in  | valid/ready         | cmd, coord_x, coord_y, heading
//  out_ch  | out | valid/ready         | wheel_a/b/c/d_speed
//  apb     | in  | psel/penable/pready | register writes and reads
//
// A word that completes goal and pose starts the computation. The 4-bit serial
// multiplier, shared by all fourteen products, does most of the work until the
// result is offered. Other words only update the stored goal or pose.
// Reset is synchronous and restores registers and clears the stored goal and pose.
// A finished result holds until taken; no new word is accepted meanwhile.
`include "omni_wheel_goal_velocity_top_macros.svh"

module omni_wheel_goal_velocity_top #(
  parameter int FRAC_BITS    = owgv_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = owgv_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  owgv_in_if.sink     in_ch,
  owgv_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W  = owgv_pkg::MUL_W;
  localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CW-1:0] CORD_LAST = CW'(CORDIC_STEPS - 1);

  owgv_pkg::state_t state, state_next;

  logic [7:0]  near_gain, far_gain;
  logic [30:0] inner_radius, outer_radius, inv_wheel_radius, axle_length;

  logic signed [31:0] goal_x, goal_y, goal_heading, pose_x, pose_y, pose_heading;
  logic goal_seen, pose_seen, goal_seen_next, pose_seen_next;
  logic in_acc;

  logic signed [32:0] ex, ey, eh;
  logic [63:0] sx, sy;
  logic [61:0] ri2, ro2;
  logic [38:0] k;
  logic signed [33:0] cx, cy, cz;
  logic flip;
  logic [CW-1:0] ccnt;
  logic signed [31:0] cs, sn;
  logic signed [41:0] m_xc, m_ys, m_xs, m_yc, u, v, pa, pb, head, ka, kb;

  logic is_mul, mul_start, mul_neg, shift_frac;
  logic signed [W-1:0] op_a, op_b;
  logic [W-1:0] mag_a, mag_b;
  owgv_pkg::mul_stat_t mstat;
  logic [2*W-1:0] prod, sprod, pshift;
  logic [40:0] rmag;
  logic signed [41:0] mres;
  logic [31:0] ang, ang_f;
  logic [64:0] d2;
  logic [7:0] gain;
  logic signed [33:0] xsh, ysh, atn, xf, yf;
  logic signed [43:0] uv_sum, uv_dif;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_gain        <= 8'd10;
      far_gain         <= 8'd7;
      inner_radius     <= 31'd26214;
      outer_radius     <= 31'd45875;
      inv_wheel_radius <= 31'd1310720;
      axle_length      <= 31'd16712;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        owgv_pkg::REG_NEAR_GAIN: near_gain        <= pwdata[7:0];
        owgv_pkg::REG_FAR_GAIN:  far_gain         <= pwdata[7:0];
        owgv_pkg::REG_INNER_RAD: inner_radius     <= pwdata[30:0];
        owgv_pkg::REG_OUTER_RAD: outer_radius     <= pwdata[30:0];
        owgv_pkg::REG_INV_WHEEL: inv_wheel_radius <= pwdata[30:0];
        owgv_pkg::REG_AXLE:      axle_length      <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      owgv_pkg::REG_NEAR_GAIN: prdata = {24'd0, near_gain};
      owgv_pkg::REG_FAR_GAIN:  prdata = {24'd0, far_gain};
      owgv_pkg::REG_INNER_RAD: prdata = {1'b0, inner_radius};
      owgv_pkg::REG_OUTER_RAD: prdata = {1'b0, outer_radius};
      owgv_pkg::REG_INV_WHEEL: prdata = {1'b0, inv_wheel_radius};
      owgv_pkg::REG_AXLE:      prdata = {1'b0, axle_length};
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------- shared serial multiplier ----------------
  owgv_smul #(.W(W), .DIG(owgv_pkg::MUL_DIG)) u_smul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_in  (mag_a),
    .b_in  (mag_b),
    .stat  (mstat),
    .prod  (prod)
  );

  assign in_acc         = in_ch.valid && in_ch.ready;
  assign goal_seen_next = goal_seen || (in_acc && !in_ch.cmd);
  assign pose_seen_next = pose_seen || (in_acc && in_ch.cmd);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      owgv_pkg::S_IDLE: if (in_acc && goal_seen_next && pose_seen_next) begin
        state_next = owgv_pkg::S_DIFF;
      end
      owgv_pkg::S_DIFF: state_next = owgv_pkg::S_SQX;
      owgv_pkg::S_SQX:  if (mstat.done) state_next = owgv_pkg::S_SQY;
      owgv_pkg::S_SQY:  if (mstat.done) state_next = owgv_pkg::S_SQI;
      owgv_pkg::S_SQI:  if (mstat.done) state_next = owgv_pkg::S_SQO;
      owgv_pkg::S_SQO:  if (mstat.done) state_next = owgv_pkg::S_GAIN;
      owgv_pkg::S_GAIN: state_next = owgv_pkg::S_ANG;
      owgv_pkg::S_ANG:  if (mstat.done) state_next = owgv_pkg::S_CORD;
      owgv_pkg::S_CORD: if (ccnt == CORD_LAST) state_next = owgv_pkg::S_CLMP;
      owgv_pkg::S_CLMP: state_next = owgv_pkg::S_XC;
      owgv_pkg::S_XC:   if (mstat.done) state_next = owgv_pkg::S_YS;
      owgv_pkg::S_YS:   if (mstat.done) state_next = owgv_pkg::S_XS;
      owgv_pkg::S_XS:   if (mstat.done) state_next = owgv_pkg::S_YC;
      owgv_pkg::S_YC:   if (mstat.done) state_next = owgv_pkg::S_UV;
      owgv_pkg::S_UV:   state_next = owgv_pkg::S_PA;
      owgv_pkg::S_PA:   if (mstat.done) state_next = owgv_pkg::S_PB;
      owgv_pkg::S_PB:   if (mstat.done) state_next = owgv_pkg::S_HD;
      owgv_pkg::S_HD:   if (mstat.done) state_next = owgv_pkg::S_KA;
      owgv_pkg::S_KA:   if (mstat.done) state_next = owgv_pkg::S_KB;
      owgv_pkg::S_KB:   if (mstat.done) state_next = owgv_pkg::S_OUT;
      owgv_pkg::S_OUT:  if (out_ch.ready) state_next = owgv_pkg::S_IDLE;
      default:          state_next = owgv_pkg::S_IDLE;
    endcase
  end

  // ---------------- control outputs and operand selection ----------------
  assign uv_sum = 44'(u) + 44'(v);
  assign uv_dif = 44'(v) - 44'(u);

  always_comb begin
    is_mul     = 1'b1;
    shift_frac = 1'b0;
    op_a       = '0;
    op_b       = '0;
    unique case (state)
      owgv_pkg::S_SQX: begin op_a = W'(ex); op_b = W'(ex); end
      owgv_pkg::S_SQY: begin op_a = W'(ey); op_b = W'(ey); end
      owgv_pkg::S_SQI: begin
        op_a = W'({1'b0, inner_radius}); op_b = W'({1'b0, inner_radius});
      end
      owgv_pkg::S_SQO: begin
        op_a = W'({1'b0, outer_radius}); op_b = W'({1'b0, outer_radius});
      end
      owgv_pkg::S_ANG: begin op_a = W'(pose_heading); op_b = owgv_pkg::TURN_PER_RAD; end
      owgv_pkg::S_XC:  begin op_a = W'(ex); op_b = W'(cs); end
      owgv_pkg::S_YS:  begin op_a = W'(ey); op_b = W'(sn); end
      owgv_pkg::S_XS:  begin op_a = W'(ex); op_b = W'(sn); end
      owgv_pkg::S_YC:  begin op_a = W'(ey); op_b = W'(cs); end
      owgv_pkg::S_PA:  begin op_a = W'(uv_sum); op_b = owgv_pkg::HALF_SQRT2; end
      owgv_pkg::S_PB:  begin op_a = W'(uv_dif); op_b = owgv_pkg::HALF_SQRT2; end
      owgv_pkg::S_HD:  begin
        op_a = W'(eh); op_b = W'({1'b0, axle_length}); shift_frac = 1'b1;
      end
      owgv_pkg::S_KA:  begin op_a = W'(pa); op_b = W'({1'b0, k}); shift_frac = 1'b1; end
      owgv_pkg::S_KB:  begin op_a = W'(pb); op_b = W'({1'b0, k}); shift_frac = 1'b1; end
      default:         is_mul = 1'b0;
    endcase
    mag_a     = op_a[W-1] ? W'(-op_a) : op_a;
    mag_b     = op_b[W-1] ? W'(-op_b) : op_b;
    mul_start = is_mul && !mstat.busy && !mstat.done;
  end

  assign in_ch.ready  = (state == owgv_pkg::S_IDLE);
  assign out_ch.valid = (state == owgv_pkg::S_OUT);

  // Product scaling: truncate the magnitude, clip at 2^40, then restore the sign.
  always_comb begin
    pshift = shift_frac ? (prod >> FRAC_BITS) : (prod >> 30);
    rmag   = (pshift > (2*W)'(owgv_pkg::PROD_LIM)) ? owgv_pkg::PROD_LIM : pshift[40:0];
    mres   = mul_neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    sprod  = mul_neg ? -prod : prod;
    ang    = sprod[FRAC_BITS+31 -: 32];
    // The half turn is added when the angle lies outside [-1/4, 1/4) turn.
    ang_f  = {ang[31] ^ (ang[31] ^ ang[30]), ang[30:0]};
    d2     = {1'b0, sx} + {1'b0, sy};
    if (d2 < 65'(ri2)) begin
      gain = 8'd0;
    end else if (d2 < 65'(ro2)) begin
      gain = near_gain;
    end else begin
      gain = far_gain;
    end
    xsh = cx >>> ccnt;
    ysh = cy >>> ccnt;
    atn = owgv_pkg::atan_turn(5'(ccnt));
    xf  = flip ? -cx : cx;
    yf  = flip ? -cy : cy;
  end

  // ---------------- state and datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= owgv_pkg::S_IDLE;
      goal_seen    <= 1'b0;
      pose_seen    <= 1'b0;
      goal_x       <= '0;
      goal_y       <= '0;
      goal_heading <= '0;
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      state     <= state_next;
      goal_seen <= goal_seen_next;
      pose_seen <= pose_seen_next;
      if (in_acc && !in_ch.cmd) begin
        goal_x       <= in_ch.coord_x;
        goal_y       <= in_ch.coord_y;
        goal_heading <= in_ch.heading;
      end
      if (in_acc && in_ch.cmd) begin
        pose_x       <= in_ch.coord_x;
        pose_y       <= in_ch.coord_y;
        pose_heading <= in_ch.heading;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mul_neg <= op_a[W-1] ^ op_b[W-1];
    end
    unique case (state)
      owgv_pkg::S_DIFF: begin
        ex <= 33'(goal_x) - 33'(pose_x);
        ey <= 33'(goal_y) - 33'(pose_y);
        eh <= 33'(goal_heading) - 33'(pose_heading);
      end
      owgv_pkg::S_SQX: if (mstat.done) sx  <= prod[63:0];
      owgv_pkg::S_SQY: if (mstat.done) sy  <= prod[63:0];
      owgv_pkg::S_SQI: if (mstat.done) ri2 <= prod[61:0];
      owgv_pkg::S_SQO: if (mstat.done) ro2 <= prod[61:0];
      owgv_pkg::S_GAIN: k <= 39'(gain) * 39'(inv_wheel_radius);
      owgv_pkg::S_ANG: if (mstat.done) begin
        flip <= ang[31] ^ ang[30];
        cx   <= owgv_pkg::CORDIC_START;
        cy   <= '0;
        cz   <= 34'($signed(ang_f));
        ccnt <= '0;
      end
      owgv_pkg::S_CORD: begin
        if (!cz[33]) begin
          cx <= cx - ysh;
          cy <= cy + xsh;
          cz <= cz - atn;
        end else begin
          cx <= cx + ysh;
          cy <= cy - xsh;
          cz <= cz + atn;
        end
        ccnt <= ccnt + 1'b1;
      end
      owgv_pkg::S_CLMP: begin
        cs <= (xf > owgv_pkg::ONE_Q30) ? 32'(owgv_pkg::ONE_Q30) :
              (xf < -owgv_pkg::ONE_Q30) ? 32'(-owgv_pkg::ONE_Q30) : xf[31:0];
        sn <= (yf > owgv_pkg::ONE_Q30) ? 32'(owgv_pkg::ONE_Q30) :
              (yf < -owgv_pkg::ONE_Q30) ? 32'(-owgv_pkg::ONE_Q30) : yf[31:0];
      end
      owgv_pkg::S_XC: if (mstat.done) m_xc <= mres;
      owgv_pkg::S_YS: if (mstat.done) m_ys <= mres;
      owgv_pkg::S_XS: if (mstat.done) m_xs <= mres;
      owgv_pkg::S_YC: if (mstat.done) m_yc <= mres;
      owgv_pkg::S_UV: begin
        u <= m_xc - m_ys;
        v <= m_xs + m_yc;
      end
      owgv_pkg::S_PA: if (mstat.done) pa   <= mres;
      owgv_pkg::S_PB: if (mstat.done) pb   <= mres;
      owgv_pkg::S_HD: if (mstat.done) head <= mres;
      owgv_pkg::S_KA: if (mstat.done) ka   <= mres;
      owgv_pkg::S_KB: if (mstat.done) kb   <= mres;
      default: ;
    endcase
  end

  // Wheels c and d see the negated projections of a and b.
  assign out_ch.wheel_a_speed = owgv_pkg::sat32(43'(head) + 43'(ka));
  assign out_ch.wheel_b_speed = owgv_pkg::sat32(43'(head) + 43'(kb));
  assign out_ch.wheel_c_speed = owgv_pkg::sat32(43'(head) - 43'(ka));
  assign out_ch.wheel_d_speed = owgv_pkg::sat32(43'(head) - 43'(kb));

  // ---------------- assertions ----------------
  `OWGV_ASSERT_NOW(a_out_needs_both, out_ch.valid, goal_seen && pose_seen, "result before goal and pose")
  `OWGV_ASSERT_NEXT(a_start_work, in_acc && goal_seen_next && pose_seen_next, state == owgv_pkg::S_DIFF, "complete word did not start work")
  `OWGV_ASSERT_NOW(a_mul_idle, state == owgv_pkg::S_IDLE || state == owgv_pkg::S_OUT, !mstat.busy, "multiplier busy outside work")
  `OWGV_ASSERT_NOW(a_no_start_busy, mul_start, !mstat.busy, "multiplier restarted while busy")

endmodule
